FILE: rtl/core/biquad_subband_filter_bank_macros.svh
// Assertion macros for the biquad subband filter bank.
`ifndef BIQUAD_SUBBAND_FILTER_BANK_MACROS_SVH
`define BIQUAD_SUBBAND_FILTER_BANK_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BSFB_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define BSFB_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`else

`define BSFB_ASSERT_NOW(label, clk, rst, pre, post, msg)
`define BSFB_ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

FILE: rtl/core/bsfb_pkg.sv
// Shared types and constants of the biquad subband filter bank.
package bsfb_pkg;

  localparam int NUM_BANDS     = 64;
  localparam int STORE_BANDS   = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int DELAY_BITS    = 24;
  localparam int COEF_BITS     = 16;
  localparam int COEF_FRAC     = 14;
  localparam int NUM_COEFS     = 5;
  localparam int BAND_BITS     = 6;
  localparam int PROD_BITS     = COEF_BITS + DELAY_BITS;
  localparam int ACC_BITS      = PROD_BITS + 2;
  localparam int SCALED_BITS   = ACC_BITS - COEF_FRAC;

  localparam logic CMD_COEF   = 1'b0;
  localparam logic CMD_FILTER = 1'b1;

  typedef logic [2:0] coef_sel_t;
  localparam coef_sel_t C_A1 = 3'd0;
  localparam coef_sel_t C_A2 = 3'd1;
  localparam coef_sel_t C_B0 = 3'd2;
  localparam coef_sel_t C_B1 = 3'd3;
  localparam coef_sel_t C_B2 = 3'd4;

  typedef struct packed {
    logic               command;
    logic [5:0]         band;
    coef_sel_t          coef_select;
    logic signed [15:0] coef_value;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         band_index;
    logic signed [15:0] band_output;
    logic               last_band;
  } out_item_t;

  typedef struct packed {
    logic                 clear;
    logic                 coef_we;
    logic                 take_sample;
    logic                 rd_en;
    logic                 mul_en;
    coef_sel_t            mul_coef;
    logic                 acc_init;
    logic                 acc_add;
    logic                 calc_d;
    logic                 calc_y;
    logic                 last;
    logic [BAND_BITS-1:0] addr;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/core/bsfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/bsfb_ctrl.sv
// Sequencer of the biquad subband filter bank: clear pass, commands, band loop.
module bsfb_ctrl
  import bsfb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_command,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     req_stall
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_MA1   = 4'd3;
  localparam logic [3:0] S_MA2   = 4'd4;
  localparam logic [3:0] S_SUMD  = 4'd5;
  localparam logic [3:0] S_CALCD = 4'd6;
  localparam logic [3:0] S_MB0   = 4'd7;
  localparam logic [3:0] S_MB1   = 4'd8;
  localparam logic [3:0] S_MB2   = 4'd9;
  localparam logic [3:0] S_SUMY  = 4'd10;
  localparam logic [3:0] S_CALCY = 4'd11;

  localparam logic [BAND_BITS-1:0] LAST_BAND  = BAND_BITS'(NUM_BANDS - 1);
  localparam logic [BAND_BITS-1:0] LAST_STORE = BAND_BITS'(STORE_BANDS - 1);

  logic [3:0]           state, state_next;
  logic [BAND_BITS-1:0] band, band_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      band  <= '0;
    end else begin
      state <= state_next;
      band  <= band_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.addr   = band;
    cmd.last   = (band == LAST_BAND);
    state_next = state;
    band_next  = band;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        band_next = band + 1'b1;
        if (band == LAST_STORE) begin
          band_next  = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          if (req_command == CMD_FILTER) begin
            cmd.take_sample = 1'b1;
            band_next       = '0;
            state_next      = S_READ;
          end else begin
            cmd.coef_we = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_MA1;
      end
      S_MA1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_coef = C_A1;
        cmd.acc_init = 1'b1;
        state_next   = S_MA2;
      end
      S_MA2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_coef = C_A2;
        cmd.acc_add  = 1'b1;
        state_next   = S_SUMD;
      end
      S_SUMD: begin
        cmd.acc_add = 1'b1;
        state_next  = S_CALCD;
      end
      S_CALCD: begin
        cmd.calc_d = 1'b1;
        state_next = S_MB0;
      end
      S_MB0: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_coef = C_B0;
        cmd.acc_init = 1'b1;
        state_next   = S_MB1;
      end
      S_MB1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_coef = C_B1;
        cmd.acc_add  = 1'b1;
        state_next   = S_MB2;
      end
      S_MB2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_coef = C_B2;
        cmd.acc_add  = 1'b1;
        state_next   = S_SUMY;
      end
      S_SUMY: begin
        cmd.acc_add = 1'b1;
        state_next  = S_CALCY;
      end
      S_CALCY: begin
        if (!stat.out_busy) begin
          cmd.calc_y = 1'b1;
          if (band == LAST_BAND) begin
            state_next = S_IDLE;
          end else begin
            band_next  = band + 1'b1;
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
        band_next  = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/bsfb_datapath.sv
// Datapath of the biquad subband filter bank: stores, shared MAC, saturation, output register.
module bsfb_datapath
  import bsfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ctl_cmd_t  cmd,
  input  in_item_t  req,
  output dp_stat_t  stat,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  localparam int DSUM_BITS = SCALED_BITS + 1;
  localparam logic signed [ACC_BITS-1:0] ROUND_CONST = ACC_BITS'(2 ** (COEF_FRAC - 1));
  localparam logic signed [DSUM_BITS-1:0] D_MAX = DSUM_BITS'((2 ** (DELAY_BITS - 1)) - 1);
  localparam logic signed [DSUM_BITS-1:0] D_MIN = -D_MAX - DSUM_BITS'(1);
  localparam logic signed [SCALED_BITS-1:0] Y_MAX =
    SCALED_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SCALED_BITS-1:0] Y_MIN = -Y_MAX - SCALED_BITS'(1);

  logic [COEF_BITS-1:0]      coef_rd [NUM_COEFS];
  logic [NUM_COEFS-1:0]      coef_we;
  logic [BAND_BITS-1:0]      coef_waddr;
  logic [COEF_BITS-1:0]      coef_wdata;
  logic                      band_ok;

  logic [2*DELAY_BITS-1:0]   dly_rd;
  logic [2*DELAY_BITS-1:0]   dly_wdata;
  logic                      dly_we;

  logic signed [DELAY_BITS-1:0]  d1, d2, d_q, d_new, op;
  logic signed [COEF_BITS-1:0]   coef;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic signed [ACC_BITS-1:0]    acc_q;
  logic signed [SCALED_BITS-1:0] scaled;
  logic signed [DSUM_BITS-1:0]   d_sum;
  logic signed [SCALED_BITS-1:0] y_sat;
  logic signed [15:0]            x_q;

  assign band_ok    = ({1'b0, req.band} < (BAND_BITS + 1)'(NUM_BANDS));
  assign coef_waddr = cmd.clear ? cmd.addr : req.band;
  assign coef_wdata = cmd.clear ? '0 : req.coef_value;

  for (genvar i = 0; i < NUM_COEFS; i++) begin : g_coef
    assign coef_we[i] = cmd.clear ||
                        (cmd.coef_we && band_ok && (req.coef_select == coef_sel_t'(i)));
    bsfb_ram #(.WIDTH(COEF_BITS), .DEPTH(STORE_BANDS)) u_coef_ram (
      .clk   (clk),
      .we    (coef_we[i]),
      .waddr (coef_waddr),
      .wdata (coef_wdata),
      .re    (cmd.rd_en),
      .raddr (cmd.addr),
      .rdata (coef_rd[i])
    );
  end

  // delay word holds {d1, d2}
  assign d1        = dly_rd[2*DELAY_BITS-1:DELAY_BITS];
  assign d2        = dly_rd[DELAY_BITS-1:0];
  assign dly_we    = cmd.clear || cmd.calc_d;
  assign dly_wdata = cmd.clear ? '0 : {d_new, d1};

  bsfb_ram #(.WIDTH(2 * DELAY_BITS), .DEPTH(STORE_BANDS)) u_delay_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (cmd.addr),
    .wdata (dly_wdata),
    .re    (cmd.rd_en),
    .raddr (cmd.addr),
    .rdata (dly_rd)
  );

  always_comb begin
    unique case (cmd.mul_coef)
      C_A1:    begin coef = coef_rd[0]; op = d1;  end
      C_A2:    begin coef = coef_rd[1]; op = d2;  end
      C_B0:    begin coef = coef_rd[2]; op = d_q; end
      C_B1:    begin coef = coef_rd[3]; op = d1;  end
      C_B2:    begin coef = coef_rd[4]; op = d2;  end
      default: begin coef = coef_rd[0]; op = d1;  end
    endcase
  end

  assign scaled = acc_q[ACC_BITS-1:COEF_FRAC];
  assign d_sum  = {scaled[SCALED_BITS-1], scaled} +
                  {{(DSUM_BITS - 16){x_q[15]}}, x_q};

  always_comb begin
    if (d_sum > D_MAX) begin
      d_new = D_MAX[DELAY_BITS-1:0];
    end else if (d_sum < D_MIN) begin
      d_new = D_MIN[DELAY_BITS-1:0];
    end else begin
      d_new = d_sum[DELAY_BITS-1:0];
    end
  end

  always_comb begin
    if (scaled > Y_MAX) begin
      y_sat = Y_MAX;
    end else if (scaled < Y_MIN) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      x_q <= req.sample;
    end
    if (cmd.mul_en) begin
      prod_q <= coef * op;
    end
    if (cmd.acc_init) begin
      acc_q <= ROUND_CONST;
    end else if (cmd.acc_add) begin
      acc_q <= acc_q + {{(ACC_BITS - PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};
    end
    if (cmd.calc_d) begin
      d_q <= d_new;
    end
    if (cmd.calc_y) begin
      rsp.band_index  <= cmd.addr;
      rsp.band_output <= y_sat[15:0];
      rsp.last_band   <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.calc_y) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign stat.out_busy = rsp_valid && rsp_stall;

endmodule

FILE: rtl/core/biquad_subband_filter_bank.sv
// Top level of the biquad subband filter bank.
// A coefficient write (command 0) leaves the block ready for the next
// transaction at once. A sample (command 1) runs all 64 bands through one
// shared 16x24 multiplier and accumulator; each band passes through a store
// read, five products, two sums, a delay update and an output. A stalled
// result holds the sequencer at the end of the next band. After reset the
// block zeroes its coefficient and delay stores with req_stall high.
`include "biquad_subband_filter_bank_macros.svh"

module biquad_subband_filter_bank
  import bsfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bsfb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .stat        (stat),
    .cmd         (cmd),
    .req_stall   (req_stall)
  );

  bsfb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `BSFB_ASSERT_NEXT(a_filter_busy, clk, rst, req_valid && !req_stall && req.command == CMD_FILTER, req_stall, "sample transaction did not start the band loop")
  `BSFB_ASSERT_NEXT(a_coef_ready, clk, rst, req_valid && !req_stall && req.command == CMD_COEF, !req_stall, "coefficient write left the block busy")
  `BSFB_ASSERT_NEXT(a_more_bands, clk, rst, rsp_valid && !rsp_stall && !rsp.last_band, req_stall || rsp_valid, "band loop ended before the last band")
  `BSFB_ASSERT_NOW(a_load_free, clk, rst, cmd.calc_y, !(rsp_valid && rsp_stall), "result loaded over a waiting result")

endmodule

FILE: verif/biquad_subband_filter_bank_test.sv
// Self-checking testbench for the biquad subband filter bank: directed and random transactions.
module biquad_subband_filter_bank_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bsfb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 212;

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  in_item_t  req;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  out_item_t rsp;

  logic signed [COEF_BITS-1:0]  coef_bank [NUM_BANDS*NUM_COEFS];
  logic signed [DELAY_BITS-1:0] delay_one_q [NUM_BANDS];
  logic signed [DELAY_BITS-1:0] delay_two_q [NUM_BANDS];
  out_item_t band_results_due [$];
  out_item_t due_item;

  int  failures = 0;
  int  quiet_cycles = 0;
  logic idling_enabled = 1'b1;

  biquad_subband_filter_bank dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= idling_enabled && ($urandom_range(99) < 37);
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // fixed point helpers
  function automatic longint round_scale(longint acc);
    return (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint coef(int b, coef_sel_t sel);
    return longint'(coef_bank[b*NUM_COEFS + int'(sel)]);
  endfunction

  task automatic predict_bank(input logic signed [SAMPLE_BITS-1:0] sample);
    longint    x;
    longint    d1;
    longint    d2;
    longint    d;
    longint    y;
    out_item_t item;
    x = longint'(sample);
    for (int b = 0; b < NUM_BANDS; b++) begin
      d1 = longint'(delay_one_q[b]);
      d2 = longint'(delay_two_q[b]);
      d  = clamp(x + round_scale(coef(b, C_A1) * d1 + coef(b, C_A2) * d2), DELAY_BITS);
      y  = clamp(round_scale(coef(b, C_B0) * d + coef(b, C_B1) * d1 + coef(b, C_B2) * d2),
                 SAMPLE_BITS);
      delay_two_q[b] = delay_one_q[b];
      delay_one_q[b] = d[DELAY_BITS-1:0];
      item.band_index  = b[BAND_BITS-1:0];
      item.band_output = y[SAMPLE_BITS-1:0];
      item.last_band   = (b == NUM_BANDS - 1);
      band_results_due.push_back(item);
    end
  endtask

  task automatic send_item(input in_item_t item);
    while (idling_enabled && $urandom_range(99) < 37) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (item.command == CMD_COEF) begin
      if (item.band < NUM_BANDS && item.coef_select < NUM_COEFS)
        coef_bank[int'(item.band)*NUM_COEFS + int'(item.coef_select)] = item.coef_value;
    end else begin
      predict_bank(item.sample);
    end
  endtask

  task automatic write_coef(input logic [BAND_BITS-1:0] band, input coef_sel_t sel,
                            input logic signed [COEF_BITS-1:0] value);
    in_item_t item;
    item.command     = CMD_COEF;
    item.band        = band;
    item.coef_select = sel;
    item.coef_value  = value;
    item.sample      = SAMPLE_BITS'($urandom);
    send_item(item);
  endtask

  task automatic filter_sample(input logic signed [SAMPLE_BITS-1:0] sample);
    in_item_t item;
    item.command     = CMD_FILTER;
    item.band        = BAND_BITS'($urandom);
    item.coef_select = coef_sel_t'($urandom);
    item.coef_value  = COEF_BITS'($urandom);
    item.sample      = sample;
    send_item(item);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (band_results_due.size() == 0) begin
        $error("unexpected transaction: band_index %0d band_output %0d",
               rsp.band_index, rsp.band_output);
        failures++;
      end else begin
        due_item = band_results_due.pop_front();
        if (rsp.band_index !== due_item.band_index) begin
          $error("band_index expected %0d actual %0d", due_item.band_index, rsp.band_index);
          failures++;
        end
        if (rsp.band_output !== due_item.band_output) begin
          $error("band_output expected %0d actual %0d",
                 due_item.band_output, rsp.band_output);
          failures++;
        end
        if (rsp.last_band !== due_item.last_band) begin
          $error("last_band expected %0d actual %0d", due_item.last_band, rsp.last_band);
          failures++;
        end
      end
    end
  end

  task automatic test_zero_coefficients();
    filter_sample(16'sh8000);
    filter_sample(16'sh7fff);
  endtask

  task automatic test_pass_through();
    write_coef(BAND_BITS'(0), C_B0, 16'sd16384);
    filter_sample(16'sh7fff);
    filter_sample(16'sh8000);
    filter_sample(16'sd0);
  endtask

  task automatic test_saturation();
    write_coef(BAND_BITS'(NUM_BANDS - 1), C_A1, 16'sh8000);
    write_coef(BAND_BITS'(NUM_BANDS - 1), C_A2, 16'sh7fff);
    write_coef(BAND_BITS'(NUM_BANDS - 1), C_B0, 16'sh7fff);
    write_coef(BAND_BITS'(NUM_BANDS - 1), C_B1, 16'sh8000);
    write_coef(BAND_BITS'(NUM_BANDS - 1), C_B2, 16'sh7fff);
    filter_sample(16'sh7fff);
    filter_sample(16'sh7fff);
    filter_sample(16'sh8000);
  endtask

  // selectors past b2 must leave the store untouched
  task automatic test_ignored_selects();
    for (int s = NUM_COEFS; s < 8; s++) write_coef(BAND_BITS'(5), coef_sel_t'(s), 16'sh7fff);
    filter_sample(16'sd12345);
  endtask

  task automatic test_random_filtering();
    int counted;
    int pick;
    coef_sel_t sel;
    logic signed [COEF_BITS-1:0] value;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      idling_enabled <= !(counted >= 90 && counted < 150);
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(9) == 0)
          filter_sample($urandom_range(1) ? 16'sh7fff : 16'sh8000);
        else
          filter_sample(SAMPLE_BITS'($urandom));
        counted++;
      end else if (pick < 52) begin
        write_coef(BAND_BITS'($urandom), coef_sel_t'($urandom_range(7, NUM_COEFS)),
                   COEF_BITS'($urandom));
        counted++;
      end else begin
        sel = coef_sel_t'($urandom_range(NUM_COEFS - 1));
        if ($urandom_range(99) < 15) begin
          value = COEF_BITS'($urandom);
        end else begin
          unique case (sel)
            C_A1:    value = COEF_BITS'(int'($urandom_range(24000)) - 12000);
            C_A2:    value = COEF_BITS'(-int'($urandom_range(14000)));
            default: value = COEF_BITS'(int'($urandom_range(32768)) - 16384);
          endcase
        end
        write_coef(BAND_BITS'($urandom), sel, value);
        counted++;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    foreach (coef_bank[i]) coef_bank[i] = '0;
    foreach (delay_one_q[i]) begin
      delay_one_q[i] = '0;
      delay_two_q[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_zero_coefficients();
    test_pass_through();
    test_saturation();
    test_ignored_selects();
    test_random_filtering();
    req_valid <= 1'b0;
    while (band_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
